/* design/ptbm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Partition table block mapper package
// Shared constants, command and status codes, sequencer states, reset presets.
// ----------------------------------------------------------------------------
package ptbm_pkg;

	localparam int SLOTS_DEF    = 16;
	localparam int RESERVED_DEF = 4;

	localparam int KEY_W   = 64;
	localparam int BLK_W   = 48;
	localparam int MODE_W  = 32;
	localparam int VER_W   = 32;
	localparam int OFF_W   = 60;
	localparam int CNT_W   = 24;
	localparam int MAXIO_W = 25;
	localparam int SHIFT_W = 4;

	localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd9;
	localparam logic [MAXIO_W-1:0] MAXIO_RST = 25'd65536;

	typedef enum logic [2:0] {
		CMD_ADD       = 3'd0,
		CMD_DELETE    = 3'd1,
		CMD_LOOKUP    = 3'd2,
		CMD_RESIZE    = 3'd3,
		CMD_TRANSLATE = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOOP     = 3'd1,
		ST_BOUNDS   = 3'd2,
		ST_NAMEUSED = 3'd3,
		ST_FULL     = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_UNUSED   = 3'd6,
		ST_BEYOND   = 3'd7
	} status_t;

	typedef enum logic [0:0] {
		REG_BLOCK_SHIFT = 1'd0,
		REG_MAX_IO      = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_WRITE, S_TR1, S_TR2, S_TR3, S_DONE
	} state_t;

	// Control from the sequencer to the table.
	typedef struct packed {
		logic scan_rd;   // read entry at scan index
		logic wr_add;    // write new entry
		logic wr_del;    // free entry and bump version
		logic wr_clamp;  // write clamped start and length
		logic wr_data;   // set data slot length
	} tbl_ctl_t;

	function automatic logic [KEY_W-1:0] rsv_key(input int i);
		unique case (i & 3)
			0: rsv_key = 64'h2F00000000000000;
			1: rsv_key = 64'h63746C0000000000;
			2: rsv_key = 64'h7261770000000000;
			default: rsv_key = 64'h6461746100000000;
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] rsv_mode(input int i);
		unique case (i & 3)
			0: rsv_mode = 32'h8000016D;
			1: rsv_mode = 32'h000001B4;
			default: rsv_mode = 32'h000001A0;
		endcase
	endfunction

endpackage
`default_nettype wire

/* design/ptbm_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Partition table storage
// Register file of slot entries with one read port at a chosen index and
// one write port driven by the sequencer.
// ----------------------------------------------------------------------------
module ptbm_table #(
	parameter int SLOTS    = ptbm_pkg::SLOTS_DEF,
	parameter int RESERVED = ptbm_pkg::RESERVED_DEF,
	parameter int IDX_W    = $clog2(SLOTS)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire ptbm_pkg::tbl_ctl_t       ctl,
	input  wire [IDX_W-1:0]               rd_idx,
	input  wire [IDX_W-1:0]               wr_idx,
	input  wire [ptbm_pkg::KEY_W-1:0]     wr_key,
	input  wire [ptbm_pkg::BLK_W-1:0]     wr_start,
	input  wire [ptbm_pkg::BLK_W-1:0]     wr_len,
	input  wire [ptbm_pkg::MODE_W-1:0]    wr_mode,
	output logic                          rd_used,
	output logic [ptbm_pkg::KEY_W-1:0]    rd_key,
	output logic [ptbm_pkg::BLK_W-1:0]    rd_start,
	output logic [ptbm_pkg::BLK_W-1:0]    rd_len,
	output logic [ptbm_pkg::MODE_W-1:0]   rd_mode,
	output logic [ptbm_pkg::VER_W-1:0]    rd_ver
);

	logic [SLOTS-1:0]                 used_q;
	logic [ptbm_pkg::KEY_W-1:0]       key_q   [SLOTS];
	logic [ptbm_pkg::BLK_W-1:0]       start_q [SLOTS];
	logic [ptbm_pkg::BLK_W-1:0]       len_q   [SLOTS];
	logic [ptbm_pkg::MODE_W-1:0]      mode_q  [SLOTS];
	logic [ptbm_pkg::VER_W-1:0]       ver_q   [SLOTS];

	// Entry writes; all fields have defined reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				used_q[i]  <= (i < RESERVED);
				key_q[i]   <= (i < RESERVED) ? ptbm_pkg::rsv_key(4 - RESERVED + i) : '0;
				mode_q[i]  <= (i < RESERVED) ? ptbm_pkg::rsv_mode(4 - RESERVED + i) : '0;
				start_q[i] <= '0;
				len_q[i]   <= '0;
				ver_q[i]   <= '0;
			end
		end else begin
			if (ctl.wr_add) begin
				used_q[wr_idx]  <= 1'b1;
				key_q[wr_idx]   <= wr_key;
				start_q[wr_idx] <= wr_start;
				len_q[wr_idx]   <= wr_len;
				mode_q[wr_idx]  <= wr_mode;
			end
			if (ctl.wr_del) begin
				used_q[wr_idx] <= 1'b0;
				key_q[wr_idx]  <= '0;
				ver_q[wr_idx]  <= ver_q[wr_idx] + 1'b1;
			end
			if (ctl.wr_clamp) begin
				start_q[wr_idx] <= wr_start;
				len_q[wr_idx]   <= wr_len;
			end
			if (ctl.wr_data) begin
				len_q[RESERVED-1] <= wr_len;
			end
		end
	end

	// Registered read of one entry.
	always_ff @(posedge clk) begin
		if (ctl.scan_rd) begin
			rd_used  <= used_q[rd_idx];
			rd_key   <= key_q[rd_idx];
			rd_start <= start_q[rd_idx];
			rd_len   <= len_q[rd_idx];
			rd_mode  <= mode_q[rd_idx];
			rd_ver   <= ver_q[rd_idx];
		end
	end

endmodule
`default_nettype wire

/* design/partition_table_block_mapper.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Partition table block mapper
// Command sequencer over a small partition table.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, one transfer each, and every command
// yields exactly one result transfer on m_axis. Configuration registers are
// written through cfg_we/cfg_idx/cfg_data; the user must write them only while
// the block is idle, which the block itself does not enforce. Add, delete and
// lookup scan the table one slot per cycle through a single read port and key
// comparator; add scans twice (name pass, then free-slot pass) in the worst
// case. Resize visits every unreserved slot and clamps each slot that reaches
// past the new size. Translate reads its slot, then runs its sequential
// subtract and compare steps. Unknown commands report a no-op without a scan.
// s_axis_tready is low from acceptance until the result has been taken;
// a stalled receiver holds the result in the output register and the block.
// Reset restores the reserved slots, clears the others and the disk size,
// and loads the register reset values.
// ----------------------------------------------------------------------------
module partition_table_block_mapper #(
	parameter int SLOTS    = ptbm_pkg::SLOTS_DEF,
	parameter int RESERVED = ptbm_pkg::RESERVED_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// command[2:0], name_key[66:3], first_block[114:67], end_block[162:115],
	// access_mode[194:163], total_blocks[242:195], slot[246:243],
	// byte_offset[306:247], byte_count[330:307], zero fill to 336
	input  wire [335:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// status[2:0], found_slot[6:3], found_version[38:7], found_mode[70:39],
	// start_lba[134:71], block_count[159:135], offset_in_block[174:160],
	// direct[175]
	output logic [175:0] m_axis_tdata,
	input  wire          cfg_we,
	input  wire          cfg_idx,
	input  wire [24:0]   cfg_data
);
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CW    = IDX_W + 1;

	ptbm_pkg::state_t state_q, state_d;
	ptbm_pkg::tbl_ctl_t ctl;

	logic [ptbm_pkg::SHIFT_W-1:0] shift_q;
	logic [ptbm_pkg::MAXIO_W-1:0] maxio_q;
	logic [ptbm_pkg::BLK_W-1:0]   disk_q;

	// Latched command.
	logic [2:0]                   cmd_q;
	logic [ptbm_pkg::KEY_W-1:0]   key_q;
	logic [ptbm_pkg::BLK_W-1:0]   st_q, en_q, nb_q;
	logic [ptbm_pkg::MODE_W-1:0]  md_q;
	logic [3:0]                   sl_q;
	logic [ptbm_pkg::OFF_W-1:0]   off_q;
	logic [ptbm_pkg::CNT_W-1:0]   cnt_q;

	// Scan control.
	logic [CW-1:0]    idx_q;      // slot being read
	logic             rdv_q;      // read data valid for slot cmp_q
	logic [CW-1:0]    cmp_q;
	logic             pass2_q;    // add: free-slot pass
	logic [IDX_W-1:0] wr_idx;
	logic [ptbm_pkg::BLK_W-1:0] wr_start, wr_len;

	logic rd_used;
	logic [ptbm_pkg::KEY_W-1:0]  rd_key;
	logic [ptbm_pkg::BLK_W-1:0]  rd_start, rd_len;
	logic [ptbm_pkg::MODE_W-1:0] rd_mode;
	logic [ptbm_pkg::VER_W-1:0]  rd_ver;

	// Translate working registers.
	logic [63:0] bno_q, nb2_q, tmp_q;
	logic [64:0] blk_end;

	// Result register.
	logic [2:0]  r_status_q;
	logic [3:0]  r_slot_q;
	logic [31:0] r_ver_q, r_mode_q;
	logic [63:0] r_lba_q;
	logic [24:0] r_cnt_q;
	logic [14:0] r_off_q;
	logic        r_dir_q;

	logic [ptbm_pkg::CNT_W+ptbm_pkg::OFF_W-1:0] mask;
	logic hit, accept;
	logic [ptbm_pkg::BLK_W:0] sum_e;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign mask   = ({{(ptbm_pkg::CNT_W+ptbm_pkg::OFF_W-1){1'b0}}, 1'b1} << shift_q) - 1'b1;
	assign hit    = rd_used && (rd_key == key_q);
	assign sum_e  = {1'b0, rd_start} + {1'b0, rd_len};
	assign blk_end = {1'b0, off_q} + {41'd0, cnt_q} + {1'b0, mask[59:0]};

	ptbm_table #(.SLOTS(SLOTS), .RESERVED(RESERVED)) u_table (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.rd_idx(idx_q[IDX_W-1:0]), .wr_idx(wr_idx),
		.wr_key(key_q), .wr_start(wr_start), .wr_len(wr_len), .wr_mode(md_q),
		.rd_used(rd_used), .rd_key(rd_key), .rd_start(rd_start), .rd_len(rd_len),
		.rd_mode(rd_mode), .rd_ver(rd_ver)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= ptbm_pkg::SHIFT_RST;
			maxio_q <= ptbm_pkg::MAXIO_RST;
		end else if (cfg_we) begin
			unique case (ptbm_pkg::reg_idx_t'(cfg_idx))
				ptbm_pkg::REG_BLOCK_SHIFT: shift_q <= cfg_data[3:0];
				ptbm_pkg::REG_MAX_IO:      maxio_q <= cfg_data;
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ptbm_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	// Next state and table control.
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		wr_idx   = cmp_q[IDX_W-1:0];
		wr_start = rd_start;
		wr_len   = rd_len;
		s_axis_tready = (state_q == ptbm_pkg::S_IDLE);
		m_axis_tvalid = (state_q == ptbm_pkg::S_DONE);
		unique case (state_q)
			ptbm_pkg::S_IDLE: begin
				if (accept) state_d = ptbm_pkg::S_SCAN;
			end
			ptbm_pkg::S_SCAN: begin
				ctl.scan_rd = (idx_q < CW'(SLOTS));
				if (cmd_q == ptbm_pkg::CMD_TRANSLATE) begin
					if (rdv_q) state_d = ptbm_pkg::S_TR1;
				end else if (cmd_q == ptbm_pkg::CMD_RESIZE) begin
					if (rdv_q && rd_used && (sum_e > {1'b0, nb_q})) begin
						ctl.wr_clamp = 1'b1;
						ctl.scan_rd  = 1'b0;
						wr_start = (rd_start > nb_q) ? nb_q : rd_start;
						wr_len   = (rd_start > nb_q) ? '0 : nb_q - rd_start;
					end
					if (!rdv_q && idx_q >= CW'(SLOTS)) begin
						ctl.wr_data = 1'b1;
						wr_len = nb_q;
						state_d = ptbm_pkg::S_DONE;
					end
				end else if (rdv_q && (pass2_q ? !rd_used : hit)) begin
					ctl.scan_rd = 1'b0;
					if (pass2_q) begin
						state_d = ptbm_pkg::S_WRITE;
					end else if (cmd_q == ptbm_pkg::CMD_DELETE) begin
						state_d = ptbm_pkg::S_WRITE;
					end else begin
						state_d = ptbm_pkg::S_DONE;
					end
				end else if (!rdv_q && idx_q >= CW'(SLOTS)) begin
					if (cmd_q == ptbm_pkg::CMD_ADD && !pass2_q &&
							r_status_q == ptbm_pkg::ST_OK)
						state_d = ptbm_pkg::S_SCAN;
					else
						state_d = ptbm_pkg::S_DONE;
				end
			end
			ptbm_pkg::S_WRITE: begin
				if (cmd_q == ptbm_pkg::CMD_DELETE) begin
					ctl.wr_del = (cmp_q >= CW'(RESERVED));
				end else begin
					ctl.wr_add = 1'b1;
					wr_start = st_q;
					wr_len   = en_q - st_q;
				end
				ctl.scan_rd = 1'b1;
				state_d = ptbm_pkg::S_TR3;
			end
			ptbm_pkg::S_TR1: state_d = ptbm_pkg::S_TR2;
			ptbm_pkg::S_TR2: state_d = ptbm_pkg::S_TR3;
			ptbm_pkg::S_TR3: state_d = ptbm_pkg::S_DONE;
			ptbm_pkg::S_DONE: begin
				if (m_axis_tready) state_d = ptbm_pkg::S_IDLE;
			end
			default: state_d = ptbm_pkg::S_IDLE;
		endcase
	end

	// Datapath and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q  <= '0;
			idx_q   <= '0;
			rdv_q   <= 1'b0;
			pass2_q <= 1'b0;
		end else begin
			unique case (state_q)
				ptbm_pkg::S_IDLE: begin
					if (accept) begin
						cmd_q <= s_axis_tdata[2:0];
						key_q <= s_axis_tdata[66:3];
						st_q  <= s_axis_tdata[114:67];
						en_q  <= s_axis_tdata[162:115];
						md_q  <= s_axis_tdata[194:163];
						nb_q  <= s_axis_tdata[242:195];
						sl_q  <= s_axis_tdata[246:243];
						off_q <= s_axis_tdata[306:247];
						cnt_q <= s_axis_tdata[330:307];
						pass2_q <= 1'b0;
						rdv_q   <= 1'b0;
						{r_slot_q, r_ver_q, r_mode_q, r_lba_q, r_cnt_q, r_off_q, r_dir_q} <= '0;
						r_status_q <= ptbm_pkg::ST_OK;
						// Unknown commands skip the scan and report a no-op.
						unique case (s_axis_tdata[2:0])
							ptbm_pkg::CMD_TRANSLATE: idx_q <= CW'(s_axis_tdata[246:243]);
							ptbm_pkg::CMD_RESIZE:    idx_q <= CW'(RESERVED);
							ptbm_pkg::CMD_ADD,
							ptbm_pkg::CMD_DELETE,
							ptbm_pkg::CMD_LOOKUP:    idx_q <= '0;
							default:                 idx_q <= CW'(SLOTS);
						endcase
					end
				end
				ptbm_pkg::S_SCAN: begin
					if (cmd_q == ptbm_pkg::CMD_TRANSLATE) begin
						rdv_q <= 1'b1;
						cmp_q <= idx_q;
						if (rdv_q) begin
							bno_q <= {4'd0, off_q >> shift_q};
							tmp_q <= blk_end[63:0] >> shift_q;
						end
					end else if (cmd_q == ptbm_pkg::CMD_RESIZE) begin
						disk_q <= nb_q;
						if (ctl.wr_clamp) begin
							rdv_q <= 1'b0;
						end else begin
							rdv_q <= ctl.scan_rd;
							cmp_q <= idx_q;
							if (ctl.scan_rd) idx_q <= idx_q + 1'b1;
						end
					end else if (cmd_q == ptbm_pkg::CMD_ADD && !pass2_q &&
							!rdv_q && idx_q == '0 &&
							(st_q > en_q || en_q > disk_q)) begin
						r_status_q <= ptbm_pkg::ST_BOUNDS;
						idx_q <= CW'(SLOTS);
					end else if (rdv_q && (pass2_q ? !rd_used : hit)) begin
						rdv_q <= 1'b0;
						// A reserved slot cannot be deleted and reports not found.
						if (!pass2_q && cmd_q == ptbm_pkg::CMD_DELETE &&
								cmp_q < CW'(RESERVED)) begin
							r_status_q <= ptbm_pkg::ST_NOTFOUND;
						end else begin
							r_slot_q <= 4'(cmp_q);
							r_ver_q  <= (!pass2_q && cmd_q == ptbm_pkg::CMD_DELETE) ?
								rd_ver + 1'b1 : rd_ver;
							r_mode_q <= pass2_q ? md_q : rd_mode;
							if (!pass2_q && cmd_q == ptbm_pkg::CMD_ADD)
								r_status_q <= (rd_start == st_q && rd_len == en_q - st_q &&
									rd_mode == md_q) ? ptbm_pkg::ST_NOOP :
									ptbm_pkg::ST_NAMEUSED;
						end
						idx_q <= cmp_q;
					end else if (!rdv_q && idx_q >= CW'(SLOTS)) begin
						if (r_status_q == ptbm_pkg::ST_OK) begin
							if (cmd_q == ptbm_pkg::CMD_ADD && !pass2_q) begin
								pass2_q <= 1'b1;
								idx_q <= '0;
							end else if (cmd_q == ptbm_pkg::CMD_ADD) begin
								r_status_q <= ptbm_pkg::ST_FULL;
							end else if (cmd_q == ptbm_pkg::CMD_DELETE ||
									cmd_q == ptbm_pkg::CMD_LOOKUP) begin
								r_status_q <= ptbm_pkg::ST_NOTFOUND;
							end else begin
								r_status_q <= ptbm_pkg::ST_NOOP;
							end
						end
					end else begin
						rdv_q <= ctl.scan_rd;
						cmp_q <= idx_q;
						if (ctl.scan_rd) idx_q <= idx_q + 1'b1;
					end
				end
				ptbm_pkg::S_WRITE: begin
					// Delete of a reserved hit keeps the not-found status.
					rdv_q <= 1'b0;
				end
				ptbm_pkg::S_TR1: begin
					// Blocks spanned, then cap by partition end.
					if (sl_q >= 4'(SLOTS) && SLOTS < 16 || !rd_used) begin
						r_status_q <= ptbm_pkg::ST_UNUSED;
					end else if (bno_q >= {16'd0, rd_len}) begin
						r_status_q <= ptbm_pkg::ST_BEYOND;
					end
					nb2_q <= tmp_q - bno_q;
					tmp_q <= {16'd0, rd_len} - bno_q;
				end
				ptbm_pkg::S_TR2: begin
					if (bno_q + nb2_q > {16'd0, rd_len}) nb2_q <= tmp_q;
				end
				ptbm_pkg::S_TR3: begin
					if (cmd_q == ptbm_pkg::CMD_TRANSLATE && r_status_q == ptbm_pkg::ST_OK) begin
						logic [63:0] nb3;
						nb3 = ((nb2_q << shift_q) > {39'd0, maxio_q}) ?
							{39'd0, maxio_q >> shift_q} : nb2_q;
						if ((nb2_q >> (7'd64 - 7'(shift_q))) != 0 && shift_q != 0)
							nb3 = {39'd0, maxio_q >> shift_q};
						if (nb3 == 0) begin
							r_status_q <= ptbm_pkg::ST_BEYOND;
						end else begin
							r_slot_q <= sl_q;
							r_ver_q  <= rd_ver;
							r_mode_q <= rd_mode;
							r_lba_q  <= bno_q + {16'd0, rd_start};
							r_cnt_q  <= nb3[24:0];
							r_off_q  <= off_q[14:0] & mask[14:0];
							r_dir_q  <= ((off_q & mask[59:0]) == 0) &&
								((cnt_q & mask[23:0]) == 0);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tdata = {r_dir_q, r_off_q, r_cnt_q, r_lba_q, r_mode_q, r_ver_q,
		r_slot_q, r_status_q};

endmodule
`default_nettype wire
